// ----- sv/hgq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hgq_pkg;

  // Height and register widths
  localparam int HEIGHT_W = 32;
  localparam int LEVEL_CNT_W = 9;
  localparam int ROW_LEN_W = 17;
  localparam int LEVEL_W = 8;

  // Magnitude width of span * (i + 1) and of the divider dividend
  localparam int PROD_W = 42;

  // Hard cap on levels from the 8-bit level field
  localparam int LEVEL_CAP = 256;

  // Header span is divided by this to get the 1% tolerance
  localparam int PERCENT_DIV = 100;

  // Scaled reciprocal of PERCENT_DIV, rounded up; exact for spans below 2^33
  localparam int TOL_SHIFT = 40;
  localparam int RECIP_W = 34;
  localparam logic [RECIP_W-1:0] TOL_RECIP =
    RECIP_W'(((64'd1 << TOL_SHIFT) + 64'(PERCENT_DIV) - 64'd1) / 64'(PERCENT_DIV));

  localparam int DEF_MAX_SAMPLES = 65536;
  localparam int DEF_MAX_LEVELS = 256;

  typedef enum logic [1:0] {
    REG_HEADER_LOW  = 2'd0,
    REG_HEADER_HIGH = 2'd1,
    REG_LEVEL_COUNT = 2'd2,
    REG_ROW_LENGTH  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic signed [HEIGHT_W-1:0]  sample;
  } cmd_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0]  header_low;
    logic signed [HEIGHT_W-1:0]  header_high;
    logic [LEVEL_CNT_W-1:0]      level_count;
    logic [ROW_LEN_W-1:0]        row_length;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/height_grid_auto_range_quantizer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Height grid quantizer: load beats store signed Q16.16 samples and track the
// in-range minimum and maximum; emit beats return one color level per stored
// sample of the whole rows, rows in reverse load order. The first load after
// a header write first refreshes the 1% tolerance with a split reciprocal
// multiply. The first emit after loading runs the bit-serial divider on the
// row count, sets up the total and row base, and builds the bound table, one
// divider pass per bound. Each emit then does one grid memory read and a
// serial scan of the bound memory, one bound tried at a time.
// A two-beat queue sits between the input and the back end, and the result
// has its own output register.
module height_grid_auto_range_quantizer #(
  parameter int MAX_SAMPLES = hgq_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_LEVELS  = hgq_pkg::DEF_MAX_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [31:0] sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       level,
  output logic             last_pixel
);
  import hgq_pkg::*;

  cfg_t     cfg;
  reg_idx_t widx;
  logic     hdr_write;
  cmd_t     cmd;
  logic     cmd_valid;
  logic     cmd_pop;

  assign widx = reg_idx_t'(cfg_index);
  assign hdr_write = cfg_we && (widx == REG_HEADER_LOW || widx == REG_HEADER_HIGH);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_low <= '0;
      cfg.header_high <= '0;
      cfg.level_count <= LEVEL_CNT_W'(1);
      cfg.row_length <= ROW_LEN_W'(1);
    end else if (cfg_we) begin
      unique case (widx)
        REG_HEADER_LOW:  cfg.header_low <= cfg_data;
        REG_HEADER_HIGH: cfg.header_high <= cfg_data;
        REG_LEVEL_COUNT: cfg.level_count <= cfg_data[LEVEL_CNT_W-1:0];
        REG_ROW_LENGTH:  cfg.row_length <= cfg_data[ROW_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hgq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .sample    (sample),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  hgq_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_LEVELS  (MAX_LEVELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hdr_write  (hdr_write),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .level      (level),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire

// ----- sv/hgq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hgq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          action,
  input  wire logic [31:0]   sample,
  output hgq_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_pop
);
  import hgq_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       in_cmd;

  // Classify the incoming beat
  always_comb begin
    in_cmd.op = action ? OP_EMIT : OP_LOAD;
    in_cmd.sample = sample;
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  // Hold up to two classified beats for the back end
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

`default_nettype wire

// ----- sv/hgq_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hgq_div #(
  parameter int NW  = 42,
  parameter int DVW = 17
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [NW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                done,
  output logic [NW-1:0]       quotient
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo;
  logic [DVW:0]    rem;
  logic [DVW-1:0]  dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DVW:0]    rem_sh;
  logic            ge;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem[DVW-1:0], quo[NW-1]};
  assign ge = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        dvs <= divisor;
        rem <= '0;
        cnt <= CNTW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/hgq_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hgq_back #(
  parameter int MAX_SAMPLES = hgq_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_LEVELS  = hgq_pkg::DEF_MAX_LEVELS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  hgq_pkg::cfg_t     cfg,
  input  wire logic         hdr_write,
  input  hgq_pkg::cmd_t     cmd,
  input  wire logic         cmd_valid,
  output logic              cmd_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        level,
  output logic              last_pixel
);
  import hgq_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int RW = (CW > ROW_LEN_W) ? CW : ROW_LEN_W;
  localparam int DVW = (CW > LEVEL_CNT_W) ? CW : LEVEL_CNT_W;
  localparam int LEVEL_LIM = (MAX_LEVELS < LEVEL_CAP) ? MAX_LEVELS : LEVEL_CAP;
  localparam int LAW = (LEVEL_LIM > 1) ? $clog2(LEVEL_LIM) : 1;
  localparam int TSPLIT = 16;
  localparam int TPL_W = TSPLIT + RECIP_W;
  localparam int TPH_W = HEIGHT_W + 1 - TSPLIT + RECIP_W;
  localparam int TSUM_W = TPH_W + TSPLIT;

  typedef enum logic [3:0] {
    S_IDLE, S_TOL, S_TOL2, S_TOL3, S_ROWS, S_TOTAL, S_BASE, S_BND, S_BNDW,
    S_GRD, S_CLAMP, S_SRD, S_SCMP
  } state_t;

  state_t state;

  // Memories
  logic signed [HEIGHT_W-1:0] grid_mem [MAX_SAMPLES];
  logic signed [HEIGHT_W-1:0] bnd_mem [LEVEL_LIM];
  logic signed [HEIGHT_W-1:0] g_q;
  logic signed [HEIGHT_W-1:0] bnd_q;
  logic [AW-1:0]              gaddr;

  // Grid tracking
  logic [CW-1:0]              loaded;
  logic signed [HEIGHT_W-1:0] run_low;
  logic signed [HEIGHT_W-1:0] run_high;
  logic                       emitting;
  logic                       hdr_dirty;
  logic signed [HEIGHT_W+1:0] accept_high;
  logic                       tol_neg;

  // Tolerance by reciprocal multiply
  logic [HEIGHT_W:0]          tol_x;
  logic [TPL_W-1:0]           tol_plo;
  logic [TPH_W-1:0]           tol_phi;
  logic [TSUM_W-1:0]          tol_sum;
  logic [HEIGHT_W:0]          tol_mag;

  // Latched emission setup
  logic signed [HEIGHT_W-1:0] lat_low;
  logic signed [HEIGHT_W-1:0] lat_high;
  logic [LEVEL_CNT_W-1:0]     lat_n;
  logic [CW-1:0]              lat_r;
  logic [CW-1:0]              rows;
  logic [CW-1:0]              total;
  logic [CW-1:0]              row_base;
  logic [CW-1:0]              col;
  logic [CW-1:0]              pos;
  logic signed [HEIGHT_W:0]   span;
  logic signed [PROD_W-1:0]   prod;
  logic [LEVEL_CNT_W-1:0]     bidx;
  logic signed [HEIGHT_W-1:0] v;

  // Divider hookup
  logic                       div_start;
  logic [PROD_W-1:0]          div_dividend;
  logic [DVW-1:0]             div_divisor;
  logic                       div_done;
  logic [PROD_W-1:0]          div_q;

  // Load path
  logic                       start_grid;
  logic [CW-1:0]              cnt_base;
  logic signed [HEIGHT_W-1:0] base_low;
  logic signed [HEIGHT_W-1:0] base_high;
  logic signed [HEIGHT_W-1:0] low_next;
  logic signed [HEIGHT_W-1:0] high_next;
  logic                       store_ok;
  logic                       grid_we;

  // Misc combinational
  logic signed [HEIGHT_W:0]   hdr_diff;
  logic [HEIGHT_W:0]          hdr_mag;
  logic [PROD_W-1:0]          prod_mag;
  logic [LEVEL_CNT_W-1:0]     n_eff;
  logic [RW-1:0]              r_ext;
  logic [CW-1:0]              r_eff;
  logic signed [HEIGHT_W+1:0] tol_s;
  logic signed [PROD_W:0]     q_s;
  logic signed [PROD_W:0]     bound_sum;
  logic                       bnd_we;
  logic                       hit;
  logic                       can_out;

  hgq_div #(.NW(PROD_W), .DVW(DVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Saturate level count and row length
  always_comb begin
    if (cfg.level_count == '0) begin
      n_eff = LEVEL_CNT_W'(1);
    end else if (cfg.level_count > LEVEL_CNT_W'(LEVEL_LIM)) begin
      n_eff = LEVEL_CNT_W'(LEVEL_LIM);
    end else begin
      n_eff = cfg.level_count;
    end
    r_ext = RW'(cfg.row_length);
    if (r_ext == '0) begin
      r_eff = CW'(1);
    end else if (r_ext > RW'(MAX_SAMPLES)) begin
      r_eff = CW'(MAX_SAMPLES);
    end else begin
      r_eff = CW'(r_ext);
    end
  end

  // Header span magnitude, running product magnitude, tolerance and bound sums
  always_comb begin
    hdr_diff = {cfg.header_high[HEIGHT_W-1], cfg.header_high}
             - {cfg.header_low[HEIGHT_W-1], cfg.header_low};
    hdr_mag = hdr_diff[HEIGHT_W] ? (HEIGHT_W+1)'(-hdr_diff) : hdr_diff;
    prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : prod;
    tol_sum = {tol_phi, {TSPLIT{1'b0}}} + TSUM_W'(tol_plo);
    tol_s = tol_neg ? -{1'b0, tol_mag} : {1'b0, tol_mag};
    q_s = prod[PROD_W-1] ? -{1'b0, div_q} : {1'b0, div_q};
    bound_sum = (PROD_W+1)'(lat_low) + q_s;
  end

  // Divider requests
  always_comb begin
    div_start = 1'b0;
    div_dividend = PROD_W'(loaded);
    div_divisor = DVW'(r_eff);
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.op == OP_EMIT && !emitting) begin
          div_start = 1'b1;
        end
      end
      S_BND: begin
        div_start = 1'b1;
        div_dividend = prod_mag;
        div_divisor = DVW'(lat_n);
      end
      default: begin
      end
    endcase
  end

  // Load: grid start, store write, range tracking; bound write enable
  always_comb begin
    start_grid = emitting || (loaded == '0);
    cnt_base = start_grid ? '0 : loaded;
    base_low = start_grid ? cfg.header_high : run_low;
    base_high = start_grid ? cfg.header_low : run_high;
    store_ok = (cnt_base < CW'(MAX_SAMPLES));
    low_next = base_low;
    high_next = base_high;
    if (cmd.sample < base_low && cmd.sample >= cfg.header_low) begin
      low_next = cmd.sample;
    end else if (cmd.sample > base_high
                 && (HEIGHT_W+2)'(cmd.sample) <= accept_high) begin
      high_next = cmd.sample;
    end
    grid_we = (state == S_IDLE) && cmd_valid && (cmd.op == OP_LOAD)
              && !hdr_dirty && store_ok;
    bnd_we = (state == S_BNDW) && div_done;
  end

  // Level search and output handoff
  assign hit = (v <= bnd_q) || (bidx == lat_n - 1'b1);
  assign can_out = !out_valid || out_ready;

  always_comb begin
    cmd_pop = 1'b0;
    if (state == S_IDLE && cmd_valid) begin
      if (cmd.op == OP_LOAD) begin
        cmd_pop = !hdr_dirty;
      end else begin
        cmd_pop = emitting && (pos >= total);
      end
    end else if (state == S_SCMP && hit && can_out) begin
      cmd_pop = 1'b1;
    end
  end

  // Grid store
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[cnt_base[AW-1:0]] <= cmd.sample;
    end
    g_q <= grid_mem[gaddr];
  end

  // Level bounds store
  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem[bidx[LAW-1:0]] <= bound_sum[HEIGHT_W-1:0];
    end
    bnd_q <= bnd_mem[bidx[LAW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      loaded <= '0;
      run_low <= '0;
      run_high <= '0;
      emitting <= 1'b0;
      hdr_dirty <= 1'b1;
      total <= '0;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result beat once taken, unless a new one lands now
      if (out_valid && out_ready && !(state == S_SCMP && hit)) begin
        out_valid <= 1'b0;
      end
      if (hdr_write) begin
        hdr_dirty <= 1'b1;
      end else if (state == S_TOL3) begin
        hdr_dirty <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == OP_LOAD) begin
              if (hdr_dirty) begin
                tol_neg <= hdr_diff[HEIGHT_W];
                tol_x <= hdr_mag;
                state <= S_TOL;
              end else begin
                emitting <= 1'b0;
                run_low <= low_next;
                run_high <= high_next;
                if (start_grid) begin
                  pos <= '0;
                end
                loaded <= store_ok ? cnt_base + 1'b1 : cnt_base;
              end
            end else if (!emitting) begin
              lat_low <= run_low;
              lat_high <= run_high;
              lat_n <= n_eff;
              lat_r <= r_eff;
              state <= S_ROWS;
            end else if (pos < total) begin
              gaddr <= AW'(row_base + col);
              state <= S_GRD;
            end
          end
        end
        // Multiply the span magnitude by the reciprocal in two halves
        S_TOL: begin
          tol_plo <= TPL_W'(tol_x[TSPLIT-1:0]) * TPL_W'(TOL_RECIP);
          tol_phi <= TPH_W'(tol_x[HEIGHT_W:TSPLIT]) * TPH_W'(TOL_RECIP);
          state <= S_TOL2;
        end
        S_TOL2: begin
          tol_mag <= (HEIGHT_W+1)'(tol_sum[TSUM_W-1:TOL_SHIFT]);
          state <= S_TOL3;
        end
        S_TOL3: begin
          accept_high <= (HEIGHT_W+2)'(cfg.header_high) - tol_s;
          state <= S_IDLE;
        end
        S_ROWS: begin
          if (div_done) begin
            rows <= div_q[CW-1:0];
            state <= S_TOTAL;
          end
        end
        S_TOTAL: begin
          total <= CW'(rows * lat_r);
          span <= (HEIGHT_W+1)'(lat_high) - (HEIGHT_W+1)'(lat_low);
          state <= S_BASE;
        end
        S_BASE: begin
          row_base <= total - lat_r;
          col <= '0;
          pos <= '0;
          prod <= PROD_W'(span);
          bidx <= '0;
          state <= S_BND;
        end
        S_BND: begin
          state <= S_BNDW;
        end
        S_BNDW: begin
          if (div_done) begin
            if (bidx == lat_n - 1'b1) begin
              emitting <= 1'b1;
              state <= S_IDLE;
            end else begin
              bidx <= bidx + 1'b1;
              prod <= prod + PROD_W'(span);
              state <= S_BND;
            end
          end
        end
        S_GRD: begin
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (g_q > lat_high) begin
            v <= lat_high;
          end else if (g_q < lat_low) begin
            v <= lat_low;
          end else begin
            v <= g_q;
          end
          bidx <= '0;
          state <= S_SRD;
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (hit) begin
            if (can_out) begin
              out_valid <= 1'b1;
              level <= bidx[LEVEL_W-1:0];
              last_pixel <= (pos + 1'b1 == total);
              pos <= pos + 1'b1;
              if (col + 1'b1 == lat_r) begin
                col <= '0;
                row_base <= row_base - lat_r;
              end else begin
                col <= col + 1'b1;
              end
              state <= S_IDLE;
            end
          end else begin
            bidx <= bidx + 1'b1;
            state <= S_SRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
